// ===== sv/varint_control_message_parser_top_assert.svh =====
// Assertion macros shared by the parser RTL.
`ifndef VARINT_CONTROL_MESSAGE_PARSER_TOP_ASSERT_SVH
`define VARINT_CONTROL_MESSAGE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define VCMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define VCMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vcmp_pkg.sv =====
// Types, constants and layout functions of the control message parser.
package vcmp_pkg;

    localparam int unsigned RECORD_LIMIT_VALUE = 64;
    localparam logic [6:0]  RECORD_LIMIT       = 7'(RECORD_LIMIT_VALUE);
    localparam logic [24:0] MAX_PAYLOAD_RESET  = 25'd16777216;
    localparam logic [2:0]  VARINT_MAX_BYTES   = 3'd5;

    localparam logic [31:0] MSG_TYPE_MIN       = 32'd21;
    localparam logic [31:0] MSG_TYPE_MAX       = 32'd30;
    localparam logic [31:0] MSG_TYPE_REQ_STR   = 32'd21;
    localparam logic [31:0] MSG_TYPE_REC_SGN   = 32'd22;
    localparam logic [31:0] MSG_TYPE_STR       = 32'd23;
    localparam logic [31:0] MSG_TYPE_REC_TAIL  = 32'd24;
    localparam logic [31:0] MSG_TYPE_SEVEN     = 32'd26;
    localparam logic [31:0] MSG_TYPE_RAW4      = 32'd28;

    localparam logic [3:0]  STEP_EXPECT_TYPE   = 4'd0;
    localparam logic [3:0]  STEP_FIRST         = 4'd1;
    localparam logic [24:0] RAW4_BYTES         = 25'd4;

    typedef enum logic [1:0] {
        KIND_FIELD   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_UNKNOWN_TYPE = 2'd0,
        ERR_VARINT_LONG  = 2'd1,
        ERR_LENGTH       = 2'd2
    } err_t;

    typedef struct packed {
        kind_t       item_kind;
        logic [31:0] message_type;
        logic [2:0]  field_slot;
        logic        in_record;
        logic [5:0]  record_number;
        logic [31:0] field_value;
        err_t        error_code;
        logic        last_of_message;
    } result_t;

    typedef struct packed {
        logic [3:0] step;
        logic [6:0] records;
        logic [5:0] position;
    } adv_t;

    // Slot number reported for a field at the given layout step.
    function automatic logic [2:0] slot_of(input logic [31:0] t, input logic [3:0] s);
        logic [2:0] r;
        r = 3'd0;
        if (t == MSG_TYPE_REQ_STR || t == MSG_TYPE_SEVEN) begin
            r = s[2:0] - 3'd1;
        end else if (t == MSG_TYPE_REC_SGN) begin
            r = (s <= 4'd2) ? (s[2:0] - 3'd1) : (s[2:0] - 3'd3);
        end else if (t == MSG_TYPE_REC_TAIL) begin
            case (s)
                4'd3:    r = 3'd1;
                4'd4:    r = 3'd2;
                4'd5:    r = 3'd3;
                4'd6:    r = 3'd1;
                default: r = 3'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic rec_of(input logic [31:0] t, input logic [3:0] s);
        return (t == MSG_TYPE_REC_SGN && s >= 4'd3 && s <= 4'd7) ||
               (t == MSG_TYPE_REC_TAIL && s >= 4'd2 && s <= 4'd5);
    endfunction

    function automatic logic is_string(input logic [31:0] t, input logic [3:0] s);
        return (t == MSG_TYPE_REQ_STR && s == 4'd2) ||
               (t == MSG_TYPE_STR && s == 4'd1) ||
               (t == MSG_TYPE_REC_TAIL && s == 4'd3);
    endfunction

    // Next layout step after the current one completes. Step zero ends the message.
    // Closing a record decrements the record count and bumps the record position.
    function automatic adv_t advance(input logic [31:0] t, input logic [3:0] s,
                                     input logic [6:0] rl, input logic [5:0] pos);
        adv_t       a;
        logic [6:0] rl_dec;
        rl_dec     = (rl != 7'd0) ? (rl - 7'd1) : 7'd0;
        a.step     = STEP_EXPECT_TYPE;
        a.records  = rl;
        a.position = pos;
        if (t == MSG_TYPE_REQ_STR) begin
            if (s == 4'd1) a.step = 4'd2;
        end else if (t == MSG_TYPE_REC_SGN) begin
            if (s == 4'd1) begin
                a.step = 4'd2;
            end else if (s == 4'd2) begin
                a.step = (rl != 7'd0) ? 4'd3 : STEP_EXPECT_TYPE;
            end else if (s >= 4'd3 && s <= 4'd6) begin
                a.step = s + 4'd1;
            end else if (s == 4'd7) begin
                a.records  = rl_dec;
                a.position = pos + 6'd1;
                a.step     = (rl_dec != 7'd0) ? 4'd3 : STEP_EXPECT_TYPE;
            end
        end else if (t == MSG_TYPE_REC_TAIL) begin
            if (s == 4'd1) begin
                a.step = (rl != 7'd0) ? 4'd2 : 4'd6;
            end else if (s >= 4'd2 && s <= 4'd4) begin
                a.step = s + 4'd1;
            end else if (s == 4'd5) begin
                a.records  = rl_dec;
                a.position = pos + 6'd1;
                a.step     = (rl_dec != 7'd0) ? 4'd2 : 4'd6;
            end
        end else if (t == MSG_TYPE_SEVEN) begin
            if (s >= 4'd1 && s <= 4'd6) a.step = s + 4'd1;
        end
        return a;
    endfunction

endpackage

// ===== sv/varint_control_message_parser_top.sv =====
// Top level of the varint control message parser.
`include "varint_control_message_parser_top_assert.svh"

// The parser takes one control-channel byte per cycle on the slave stream and
// decodes little-endian 7-bit varints (up to five bytes, low 32 bits kept).
// Each message opens with a type varint, which yields no result. Types 21 to
// 30 follow fixed layouts of fields, repeated records (count clamped to 64)
// and length-prefixed byte strings. Every completed field and every string
// byte becomes one result word on the master stream, registered in the output
// stage before it leaves; tlast marks the final word of a message.
// An unknown type, a varint running past five bytes or a string length above
// max_payload_len produces a single error word with tlast set, and every
// later byte is then swallowed without result until reset. The rate is one
// byte per cycle while s_tready is high: all state updates in one combinational
// pass, and a two-deep output register (main stage plus skid) lets s_tready
// stay high while one result word waits, dropping only when both are full.
// The max_payload_len register is written through the cfg channel, which is
// always ready; it should be written only while the parser is idle.
module varint_control_message_parser_top
    import vcmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel: max_payload_len.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data,
    // Input stream, one word per byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] stream_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,        // [31:0] message_type, [34:32] field_slot,
                                        // [35] in_record, [41:36] record_number,
                                        // [73:42] field_value, [75:74] error_code,
                                        // [79:76] zero
    output logic [1:0]  m_tuser,        // [1:0] item_kind
    output logic        m_tlast         // last_of_message
);

    // Parser state.
    logic [24:0] max_payload_len_reg, max_payload_len_next;
    logic        draining_reg, draining_next;
    logic [31:0] current_type_reg, current_type_next;
    logic [3:0]  layout_step_reg, layout_step_next;
    logic [31:0] varint_acc_reg, varint_acc_next;
    logic [2:0]  varint_cnt_reg, varint_cnt_next;
    logic [6:0]  records_left_reg, records_left_next;
    logic [5:0]  record_pos_reg, record_pos_next;
    logic [24:0] payload_left_reg, payload_left_next;
    logic        in_payload_reg, in_payload_next;

    // Output stages.
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_data_reg, out_data_next;
    result_t     skid_data_reg, skid_data_next;

    // Combinational datapath.
    logic        accept;
    logic        pop;
    logic        res_valid;
    result_t     res;
    logic [2:0]  slot;
    logic        inrec;
    logic [5:0]  shift_mul;
    logic [4:0]  shamt;
    logic [31:0] varint_value;
    logic [2:0]  cnt_inc;
    logic [24:0] pl_dec;
    logic        count_step;
    logic [6:0]  count_clamped;
    logic [6:0]  records_in;
    adv_t        adv;
    logic        str_step;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;

    assign slot  = slot_of(current_type_reg, layout_step_reg);
    assign inrec = rec_of(current_type_reg, layout_step_reg);

    // Group shift of 7 * byte count, kept modulo 32.
    assign shift_mul    = ({3'd0, varint_cnt_reg} << 3) - {3'd0, varint_cnt_reg};
    assign shamt        = shift_mul[4:0];
    assign varint_value = varint_acc_reg | ({25'd0, s_tdata[6:0]} << shamt);
    assign cnt_inc      = varint_cnt_reg + 3'd1;
    assign pl_dec       = payload_left_reg - 25'd1;
    assign str_step     = is_string(current_type_reg, layout_step_reg);

    // Record count fields: the signed one clamps negatives to zero.
    always_comb begin
        count_step    = 1'b0;
        count_clamped = 7'd0;
        if (current_type_reg == MSG_TYPE_REC_SGN && layout_step_reg == 4'd2) begin
            count_step = 1'b1;
            if (varint_value[31]) begin
                count_clamped = 7'd0;
            end else if (varint_value > {25'd0, RECORD_LIMIT}) begin
                count_clamped = RECORD_LIMIT;
            end else begin
                count_clamped = varint_value[6:0];
            end
        end else if (current_type_reg == MSG_TYPE_REC_TAIL && layout_step_reg == 4'd1) begin
            count_step    = 1'b1;
            count_clamped = (varint_value > {25'd0, RECORD_LIMIT}) ? RECORD_LIMIT
                                                                    : varint_value[6:0];
        end
    end

    assign records_in = (count_step && !in_payload_reg) ? count_clamped : records_left_reg;
    assign adv = advance(current_type_reg, layout_step_reg, records_in, record_pos_reg);

    always_comb begin
        max_payload_len_next = max_payload_len_reg;
        draining_next        = draining_reg;
        current_type_next    = current_type_reg;
        layout_step_next     = layout_step_reg;
        varint_acc_next      = varint_acc_reg;
        varint_cnt_next      = varint_cnt_reg;
        records_left_next    = records_left_reg;
        record_pos_next      = record_pos_reg;
        payload_left_next    = payload_left_reg;
        in_payload_next      = in_payload_reg;

        res_valid           = 1'b0;
        res.item_kind       = KIND_FIELD;
        res.message_type    = current_type_reg;
        res.field_slot      = slot;
        res.in_record       = inrec;
        res.record_number   = inrec ? record_pos_reg : 6'd0;
        res.field_value     = varint_value;
        res.error_code      = ERR_UNKNOWN_TYPE;
        res.last_of_message = 1'b0;

        if (cfg_valid) begin
            max_payload_len_next = cfg_data;
        end

        if (accept && !draining_reg) begin
            if (in_payload_reg) begin
                res_valid         = 1'b1;
                res.item_kind     = KIND_PAYLOAD;
                res.field_value   = {24'd0, s_tdata};
                payload_left_next = pl_dec;
                if (pl_dec == 25'd0) begin
                    in_payload_next     = 1'b0;
                    layout_step_next    = adv.step;
                    records_left_next   = adv.records;
                    record_pos_next     = adv.position;
                    res.last_of_message = (adv.step == STEP_EXPECT_TYPE);
                end
            end else if (s_tdata[7]) begin
                // Continuation byte.
                varint_acc_next = varint_value;
                varint_cnt_next = cnt_inc;
                if (cnt_inc >= VARINT_MAX_BYTES) begin
                    res_valid           = 1'b1;
                    draining_next       = 1'b1;
                    in_payload_next     = 1'b0;
                    res.item_kind       = KIND_ERROR;
                    res.message_type    = (layout_step_reg == STEP_EXPECT_TYPE) ? 32'd0
                                                                               : current_type_reg;
                    res.error_code      = ERR_VARINT_LONG;
                end
            end else begin
                varint_acc_next = 32'd0;
                varint_cnt_next = 3'd0;
                if (layout_step_reg == STEP_EXPECT_TYPE) begin
                    if (varint_value < MSG_TYPE_MIN || varint_value > MSG_TYPE_MAX) begin
                        res_valid        = 1'b1;
                        draining_next    = 1'b1;
                        in_payload_next  = 1'b0;
                        res.item_kind    = KIND_ERROR;
                        res.message_type = varint_value;
                        res.error_code   = ERR_UNKNOWN_TYPE;
                    end else begin
                        current_type_next = varint_value;
                        layout_step_next  = STEP_FIRST;
                        records_left_next = 7'd0;
                        record_pos_next   = 6'd0;
                        if (varint_value == MSG_TYPE_RAW4) begin
                            payload_left_next = RAW4_BYTES;
                            in_payload_next   = 1'b1;
                        end
                    end
                end else if (str_step && varint_value > {7'd0, max_payload_len_reg}) begin
                    res_valid       = 1'b1;
                    draining_next   = 1'b1;
                    in_payload_next = 1'b0;
                    res.item_kind   = KIND_ERROR;
                    res.error_code  = ERR_LENGTH;
                end else if (str_step && varint_value != 32'd0) begin
                    // Length field of a non-empty string; its bytes follow.
                    res_valid         = 1'b1;
                    payload_left_next = varint_value[24:0];
                    in_payload_next   = 1'b1;
                end else begin
                    res_valid           = 1'b1;
                    layout_step_next    = adv.step;
                    records_left_next   = adv.records;
                    record_pos_next     = adv.position;
                    res.last_of_message = (adv.step == STEP_EXPECT_TYPE);
                end
            end
            if (res.item_kind == KIND_ERROR) begin
                res.field_slot      = 3'd0;
                res.in_record       = 1'b0;
                res.record_number   = 6'd0;
                res.field_value     = 32'd0;
                res.last_of_message = 1'b1;
            end
        end
    end

    // Output stage control: the skid stage only fills while the main stage stalls.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_len_reg <= MAX_PAYLOAD_RESET;
            draining_reg        <= 1'b0;
            current_type_reg    <= 32'd0;
            layout_step_reg     <= STEP_EXPECT_TYPE;
            varint_acc_reg      <= 32'd0;
            varint_cnt_reg      <= 3'd0;
            records_left_reg    <= 7'd0;
            record_pos_reg      <= 6'd0;
            payload_left_reg    <= 25'd0;
            in_payload_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end else begin
            max_payload_len_reg <= max_payload_len_next;
            draining_reg        <= draining_next;
            current_type_reg    <= current_type_next;
            layout_step_reg     <= layout_step_next;
            varint_acc_reg      <= varint_acc_next;
            varint_cnt_reg      <= varint_cnt_next;
            records_left_reg    <= records_left_next;
            record_pos_reg      <= record_pos_next;
            payload_left_reg    <= payload_left_next;
            in_payload_reg      <= in_payload_next;
            out_valid_reg       <= out_valid_next;
            skid_valid_reg      <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.item_kind;
    assign m_tlast  = out_data_reg.last_of_message;
    assign m_tdata  = {4'd0,
                       out_data_reg.error_code,
                       out_data_reg.field_value,
                       out_data_reg.record_number,
                       out_data_reg.in_record,
                       out_data_reg.field_slot,
                       out_data_reg.message_type};

    `VCMP_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, out_valid_reg, "skid full, main empty")
    `VCMP_ASSERT_NOW(a_error_is_last, out_valid_reg && out_data_reg.item_kind == KIND_ERROR, out_data_reg.last_of_message, "error word without tlast")
    `VCMP_ASSERT_NEXT(a_drain_sticks, draining_reg, draining_reg, "drain state left without reset")
    `VCMP_ASSERT_NOW(a_records_bound, 1'b1, records_left_reg <= RECORD_LIMIT, "record count above limit")
    `VCMP_ASSERT_NOW(a_payload_nonzero, in_payload_reg, payload_left_reg != 25'd0, "payload mode with zero bytes left")

endmodule

// ===== bench/vcmp_result_checker.sv =====
// Stream monitor that predicts and checks every result word of the message parser.
`timescale 1ns / 100ps

module vcmp_result_checker
    import vcmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [24:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] stream_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,        // [31:0] message_type, [34:32] field_slot,
                                        // [35] in_record, [41:36] record_number,
                                        // [73:42] field_value, [75:74] error_code
    input  logic [1:0]  m_tuser,        // [1:0] item_kind
    input  logic        m_tlast,        // last_of_message
    output int          failures,
    output int          outstanding
);

    typedef struct packed {
        logic [2:0] slot;
        logic       rec;
        logic       str;
    } elem_t;

    // Parser state as the block should hold it.
    logic        drain_q;
    logic [31:0] msg_type;
    logic [3:0]  step;
    logic [31:0] acc;
    logic [2:0]  nbytes;
    logic [6:0]  recs_left;
    logic [5:0]  rec_pos;
    logic [24:0] bytes_left;
    logic        in_string;
    logic [24:0] length_limit;

    result_t predicted_words[$];

    initial failures = 0;
    initial outstanding = 0;

    // Slot, record membership and string flag of the element at a layout step.
    function automatic elem_t element_at(input logic [31:0] t, input logic [3:0] s);
        elem_t e;
        e = '0;
        case (t)
            MSG_TYPE_REQ_STR: begin
                e.str  = (s == 4'd2);
                e.slot = e.str ? 3'd1 : 3'd0;
            end
            MSG_TYPE_REC_SGN: begin
                e.rec  = (s >= 4'd3);
                e.slot = e.rec ? 3'(s - 4'd3) : 3'(s - 4'd1);
            end
            MSG_TYPE_STR: begin
                e.str = (s == 4'd1);
            end
            MSG_TYPE_REC_TAIL: begin
                e.rec  = (s >= 4'd2 && s <= 4'd5);
                e.str  = (s == 4'd3);
                e.slot = (s == 4'd6) ? 3'd1 : (e.rec ? 3'(s - 4'd2) : 3'd0);
            end
            MSG_TYPE_SEVEN: begin
                e.slot = 3'(s - 4'd1);
            end
            default: begin
            end
        endcase
        return e;
    endfunction

    // Closes a record and tells whether another one follows.
    function automatic bit close_record();
        if (recs_left != 7'd0) recs_left = recs_left - 7'd1;
        rec_pos = rec_pos + 6'd1;
        return recs_left != 7'd0;
    endfunction

    function automatic logic [3:0] step_after();
        logic [3:0] s;
        s = STEP_EXPECT_TYPE;
        case (msg_type)
            MSG_TYPE_REQ_STR: begin
                if (step == 4'd1) s = 4'd2;
            end
            MSG_TYPE_REC_SGN: begin
                if (step == 4'd1) s = 4'd2;
                else if (step == 4'd2) s = (recs_left != 7'd0) ? 4'd3 : STEP_EXPECT_TYPE;
                else if (step >= 4'd3 && step <= 4'd6) s = step + 4'd1;
                else if (step == 4'd7) s = close_record() ? 4'd3 : STEP_EXPECT_TYPE;
            end
            MSG_TYPE_REC_TAIL: begin
                if (step == 4'd1) s = (recs_left != 7'd0) ? 4'd2 : 4'd6;
                else if (step >= 4'd2 && step <= 4'd4) s = step + 4'd1;
                else if (step == 4'd5) s = close_record() ? 4'd2 : 4'd6;
            end
            MSG_TYPE_SEVEN: begin
                if (step >= 4'd1 && step <= 4'd6) s = step + 4'd1;
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic reset_parser();
        drain_q      = 1'b0;
        msg_type     = '0;
        step         = STEP_EXPECT_TYPE;
        acc          = '0;
        nbytes       = '0;
        recs_left    = '0;
        rec_pos      = '0;
        bytes_left   = '0;
        in_string    = 1'b0;
        length_limit = MAX_PAYLOAD_RESET;
    endtask

    task automatic enter_drain(input logic [31:0] t, input err_t code, output result_t r);
        drain_q           = 1'b1;
        in_string         = 1'b0;
        r                 = '0;
        r.item_kind       = KIND_ERROR;
        r.message_type    = t;
        r.error_code      = code;
        r.last_of_message = 1'b1;
    endtask

    // Advances the parser by one byte and yields the result word it causes, if any.
    task automatic decode_stream_byte(input logic [7:0] b, output bit made, output result_t r);
        elem_t       e;
        logic [31:0] v;
        made = 1'b0;
        r    = '0;
        if (drain_q) return;
        e               = element_at(msg_type, step);
        r.item_kind     = KIND_FIELD;
        r.error_code    = ERR_UNKNOWN_TYPE;
        r.message_type  = msg_type;
        r.field_slot    = e.slot;
        r.in_record     = e.rec;
        r.record_number = e.rec ? rec_pos : 6'd0;

        if (in_string) begin
            made          = 1'b1;
            bytes_left    = bytes_left - 25'd1;
            r.item_kind   = KIND_PAYLOAD;
            r.field_value = {24'd0, b};
            if (bytes_left == 25'd0) begin
                in_string         = 1'b0;
                step              = step_after();
                r.last_of_message = (step == STEP_EXPECT_TYPE);
            end
            return;
        end

        acc = acc | (32'(b[6:0]) << (7 * nbytes));
        if (b[7]) begin
            nbytes = nbytes + 3'd1;
            if (nbytes == VARINT_MAX_BYTES) begin
                made = 1'b1;
                enter_drain((step == STEP_EXPECT_TYPE) ? 32'd0 : msg_type, ERR_VARINT_LONG, r);
            end
            return;
        end
        v      = acc;
        acc    = '0;
        nbytes = '0;

        if (step == STEP_EXPECT_TYPE) begin
            if (v < MSG_TYPE_MIN || v > MSG_TYPE_MAX) begin
                made = 1'b1;
                enter_drain(v, ERR_UNKNOWN_TYPE, r);
                return;
            end
            msg_type  = v;
            step      = STEP_FIRST;
            recs_left = '0;
            rec_pos   = '0;
            if (v == MSG_TYPE_RAW4) begin
                bytes_left = RAW4_BYTES;
                in_string  = 1'b1;
            end
            return;
        end

        made          = 1'b1;
        r.field_value = v;
        if (e.str) begin
            if (v > length_limit) begin
                enter_drain(msg_type, ERR_LENGTH, r);
                return;
            end
            if (v != 32'd0) begin
                bytes_left = v[24:0];
                in_string  = 1'b1;
                return;
            end
        end
        if (msg_type == MSG_TYPE_REC_SGN && step == 4'd2) begin
            recs_left = v[31] ? 7'd0 : ((v > RECORD_LIMIT_VALUE) ? RECORD_LIMIT : v[6:0]);
        end else if (msg_type == MSG_TYPE_REC_TAIL && step == 4'd1) begin
            recs_left = (v > RECORD_LIMIT_VALUE) ? RECORD_LIMIT : v[6:0];
        end
        step              = step_after();
        r.last_of_message = (step == STEP_EXPECT_TYPE);
    endtask

    function automatic string show_word(input result_t r);
        return $sformatf(
            "kind=%0d type=0x%08h slot=%0d rec=%0b num=%0d val=0x%08h err=%0d last=%0b",
            r.item_kind, r.message_type, r.field_slot, r.in_record,
            r.record_number, r.field_value, r.error_code, r.last_of_message);
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t fresh;
        bit      made;
        if (!aresetn) begin
            reset_parser();
            predicted_words.delete();
        end else begin
            // A word leaving now was caused by an earlier byte, so compare first.
            if (m_tvalid && m_tready) begin
                got.item_kind       = kind_t'(m_tuser);
                got.message_type    = m_tdata[31:0];
                got.field_slot      = m_tdata[34:32];
                got.in_record       = m_tdata[35];
                got.record_number   = m_tdata[41:36];
                got.field_value     = m_tdata[73:42];
                got.error_code      = err_t'(m_tdata[75:74]);
                got.last_of_message = m_tlast;
                if (predicted_words.size() == 0) begin
                    if (failures < 10) $display("unexpected result word: %s", show_word(got));
                    failures++;
                end else begin
                    want = predicted_words.pop_front();
                    if (got.item_kind !== want.item_kind ||
                        got.message_type !== want.message_type ||
                        got.field_slot !== want.field_slot ||
                        got.in_record !== want.in_record ||
                        got.record_number !== want.record_number ||
                        got.field_value !== want.field_value ||
                        got.error_code !== want.error_code ||
                        got.last_of_message !== want.last_of_message) begin
                        if (failures < 10) begin
                            $display("result mismatch: expected %s", show_word(want));
                            $display("                 actual   %s", show_word(got));
                        end
                        failures++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) length_limit = cfg_data;
            if (s_tvalid && s_tready) begin
                decode_stream_byte(s_tdata, made, fresh);
                if (made) predicted_words = {predicted_words, fresh};
            end
        end
        outstanding <= predicted_words.size();
    end

endmodule

// ===== bench/tb_varint_control_message_parser_top.sv =====
// Stimulus and verdict for the varint control message parser, checked by vcmp_result_checker.
`timescale 1ns / 100ps

module tb_varint_control_message_parser_top;
    import vcmp_pkg::*;

    // The one single-value message type used for the directed varint extremes.
    localparam logic [31:0] MSG_TYPE_SCALAR = 32'd25;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT = 4000;

    // Every input of the block starts at a known value.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [24:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;

    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int failures;
    int outstanding;

    // Percentage of cycles in which the sender holds back a word and the
    // receiver refuses one.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int idle_cycles = 0;

    // Bytes of the messages being built, and the string length limit that
    // the generator currently respects so that no string errors by accident.
    logic [7:0]  stream_q[$];
    logic [24:0] payload_limit = MAX_PAYLOAD_RESET;

    always #1 aclk = ~aclk;

    varint_control_message_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    vcmp_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // The receiver decides afresh on every cycle whether it takes a word.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // The watchdog restarts whenever a word moves on any channel. A run that
    // stops moving words for this long is hung and fails at once.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic bit coin(input int odds);
        return $urandom_range(0, odds - 1) == 0;
    endfunction

    // A 32-bit value whose width is drawn first, so that short and long
    // varint encodings are both common.
    function automatic logic [31:0] rand_value();
        int w;
        w = $urandom_range(0, 32);
        return (w == 0) ? 32'd0 : ($urandom >> (32 - w));
    endfunction

    // Mostly short strings; now and then exactly the limit when it is small.
    function automatic logic [31:0] pick_len();
        int unsigned roll;
        int unsigned cap;
        roll = $urandom_range(0, 9);
        cap  = (payload_limit < 25'd6) ? payload_limit : 6;
        if (roll == 0) return 32'd0;
        if (roll == 1 && payload_limit <= 25'd16) return 32'(payload_limit);
        return $urandom_range(0, cap);
    endfunction

    // Record counts stay small in random messages. The signed count now and
    // then has its sign bit set, which it treats as zero records. The clamp
    // to the record limit is covered once by the directed part.
    function automatic logic [31:0] pick_count(input bit is_signed);
        if (is_signed) begin
            case ($urandom_range(0, 15))
                0:       return 32'h8000_0000 | $urandom;
                1:       return 32'hFFFF_FFFF;
                default: return $urandom_range(0, 3);
            endcase
        end
        return $urandom_range(0, 3);
    endfunction

    // Appends one byte to the stream being built.
    task automatic queue_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    // Little-endian 7-bit groups. Padding adds redundant groups up to the
    // five-byte maximum; in a fifth byte the three bits beyond bit 31 carry
    // junk that the parser has to drop.
    task automatic push_varint(input logic [31:0] v, input bit pad);
        int          need;
        int          total;
        logic [31:0] rest;
        logic [6:0]  group;
        need = 1;
        rest = v >> 7;
        while (rest != 0) begin
            need++;
            rest = rest >> 7;
        end
        total = pad ? $urandom_range(need, 5) : need;
        for (int i = 0; i < total; i++) begin
            group = 7'(v >> (7 * i));
            if (i == 4) group[6:4] = 3'($urandom);
            queue_byte({(i != total - 1) ? 1'b1 : 1'b0, group});
        end
    endtask

    task automatic push_field();
        push_varint(rand_value(), coin(4));
    endtask

    // A string is its length varint followed by that many raw bytes.
    task automatic push_string();
        logic [31:0] len;
        len = pick_len();
        push_varint(len, coin(4));
        repeat (len) queue_byte(8'($urandom));
    endtask

    // One complete, well-formed message of the given type with random content.
    task automatic push_message(input logic [31:0] t);
        logic [31:0] count;
        int          recs;
        push_varint(t, coin(4));
        case (t)
            MSG_TYPE_REQ_STR: begin
                push_field();
                push_string();
            end
            MSG_TYPE_REC_SGN: begin
                push_field();
                count = pick_count(1'b1);
                push_varint(count, coin(4));
                recs = count[31] ? 0 : ((count > RECORD_LIMIT_VALUE) ? RECORD_LIMIT_VALUE :
                                        int'(count));
                repeat (recs * 5) push_field();
            end
            MSG_TYPE_STR: begin
                push_string();
            end
            MSG_TYPE_REC_TAIL: begin
                count = pick_count(1'b0);
                push_varint(count, coin(4));
                recs = (count > RECORD_LIMIT_VALUE) ? RECORD_LIMIT_VALUE : int'(count);
                repeat (recs) begin
                    push_field();
                    push_string();
                    push_field();
                    push_field();
                end
                push_field();
            end
            MSG_TYPE_SEVEN: begin
                repeat (7) push_field();
            end
            MSG_TYPE_RAW4: begin
                repeat (RAW4_BYTES) queue_byte(8'($urandom));
            end
            default: begin
                push_field();
            end
        endcase
    endtask

    // One word on the input stream. Valid stays high from one word to the
    // next unless the sender decides to idle first.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic flush_stream();
        while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    endtask

    // Waits until every predicted word has left the block, lets a type varint
    // still in flight settle, and only then writes the register.
    task automatic configure(input logic [24:0] limit);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid     <= 1'b0;
        payload_limit = limit;
    endtask

    // Every message type once, then the corner cases of varints, strings,
    // record counts and raw bytes.
    task automatic run_directed();
        for (logic [31:0] t = MSG_TYPE_MIN; t <= MSG_TYPE_MAX; t++) push_message(t);
        // Smallest and largest values, and a padded small value.
        push_varint(MSG_TYPE_SCALAR, 1'b0);
        push_varint(32'd0, 1'b0);
        push_varint(MSG_TYPE_SCALAR, 1'b0);
        push_varint(32'hFFFF_FFFF, 1'b0);
        push_varint(MSG_TYPE_SCALAR, 1'b1);
        push_varint(32'd127, 1'b1);
        // Five-byte zero whose top byte holds only bits above bit 31.
        push_varint(MSG_TYPE_SCALAR, 1'b0);
        queue_byte(8'h80);
        queue_byte(8'h80);
        queue_byte(8'h80);
        queue_byte(8'h80);
        queue_byte(8'h70);
        // An empty string ends its message on the length field.
        push_varint(MSG_TYPE_STR, 1'b0);
        push_varint(32'd0, 1'b0);
        push_varint(MSG_TYPE_REQ_STR, 1'b0);
        push_field();
        push_varint(32'd0, 1'b0);
        // A negative signed count and a zero count both mean no records.
        push_varint(MSG_TYPE_REC_SGN, 1'b0);
        push_field();
        push_varint(32'hFFFF_FFFF, 1'b0);
        push_varint(MSG_TYPE_REC_SGN, 1'b0);
        push_field();
        push_varint(32'd0, 1'b0);
        // With no records the next field is the trailing one.
        push_varint(MSG_TYPE_REC_TAIL, 1'b0);
        push_varint(32'd0, 1'b0);
        push_field();
        // A huge unsigned count is clamped to the record limit. The records
        // are kept to one byte per element so that the run stays short.
        push_varint(MSG_TYPE_REC_TAIL, 1'b0);
        push_varint(32'h8000_0041, 1'b0);
        repeat (RECORD_LIMIT_VALUE) begin
            push_varint(32'd0, 1'b0);
            push_varint(32'd0, 1'b0);
            push_varint(32'd0, 1'b0);
            push_varint(32'd0, 1'b0);
        end
        push_field();
        // Raw bytes, two of which would read as varint continuations.
        push_varint(MSG_TYPE_RAW4, 1'b0);
        queue_byte(8'h80);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'h7F);
        flush_stream();
    endtask

    // Random messages until the byte budget of the phase is spent.
    task automatic run_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            push_message($urandom_range(MSG_TYPE_MIN, MSG_TYPE_MAX));
            sent += stream_q.size();
            flush_stream();
        end
    endtask

    // Any error leaves the parser draining until reset, and reset comes only
    // once, so exactly one error kind is drawn for the end of the run. The
    // bytes after it must all be swallowed without a result word.
    task automatic push_error_tail();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'd0;
                    1:       v = MSG_TYPE_MIN - 32'd1;
                    2:       v = MSG_TYPE_MAX + 32'd1;
                    default: v = 32'h8000_0000 | $urandom;
                endcase
                push_varint(v, coin(2));
            end
            1: begin
                // A type varint that never ends.
                repeat (5) queue_byte(8'h80 | 8'($urandom));
            end
            2: begin
                // A field varint that never ends, in the middle of a message.
                push_varint(MSG_TYPE_SEVEN, 1'b0);
                push_field();
                push_field();
                repeat (5) queue_byte(8'h80 | 8'($urandom));
            end
            default: begin
                // A string length just above the limit, or the largest one.
                push_varint(MSG_TYPE_STR, 1'b0);
                push_varint(coin(2) ? 32'hFFFF_FFFF : 32'(payload_limit) + 32'd1, coin(4));
            end
        endcase
        repeat (16) queue_byte(8'($urandom));
        flush_stream();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender idles a quarter of the time, receiver most of the time.
        // The register keeps its reset value for the directed part.
        tx_idle_pct = 25;
        rx_idle_pct = 64;
        run_directed();
        configure(25'd0);
        run_random(20);

        // The other way round, with a tiny limit and then the reset value.
        tx_idle_pct = 64;
        rx_idle_pct = 25;
        configure(25'd3);
        run_random(20);
        configure(MAX_PAYLOAD_RESET);
        run_random(20);

        // No idling at all, with a random limit of any size and a small one.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(25'($urandom_range(0, MAX_PAYLOAD_RESET)));
        run_random(20);
        configure(25'($urandom_range(1, 16)));
        run_random(20);

        push_error_tail();
        s_tvalid <= 1'b0;

        // Let the last words drain, then keep waiting so that the block can
        // show any word it should not produce.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (failures == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
